// ===== design/http_request_byte_parser_unit_defines.svh =====
// Assertion macros for the HTTP request byte parser.
// No dependencies; included by the top level.
`ifndef HTTP_REQUEST_BYTE_PARSER_UNIT_DEFINES_SVH
`define HTTP_REQUEST_BYTE_PARSER_UNIT_DEFINES_SVH
// Assert that an implication holds on every clock edge out of reset.
`define HRBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert that a condition implies another on the next edge.
`define HRBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/hrbp_pkg.sv =====
// Package for the HTTP request byte parser: phase codes, status and class codes,
// and character helper functions. No dependencies.
`timescale 1ns / 1ps
package hrbp_pkg;
    typedef enum logic [4:0] {
        P_METHOD_START, P_METHOD, P_URI, P_VH, P_VT1, P_VT2, P_VP, P_VSLASH,
        P_MAJ_START, P_MAJ, P_MAJ_DOT, P_MIN, P_NL1, P_LINE_START, P_LWS, P_NAME,
        P_SP_VALUE, P_VALUE, P_NL2, P_NL3, P_BODY, P_CSIZE_START, P_CSIZE,
        P_CPARAMS, P_CSIZE_END, P_CDATA, P_CDATA_CR, P_CDATA_LF
    } phase_t;

    localparam logic [1:0] ST_MORE = 2'd0;
    localparam logic [1:0] ST_GOOD = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [2:0] CLS_FRAME = 3'd0;
    localparam logic [2:0] CLS_METHOD = 3'd1;
    localparam logic [2:0] CLS_URI = 3'd2;
    localparam logic [2:0] CLS_NAME = 3'd3;
    localparam logic [2:0] CLS_VALUE = 3'd4;
    localparam logic [2:0] CLS_BODY = 3'd5;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic [7:0] KEY_CL [14] = '{"c","o","n","t","e","n","t","-",
                                             "l","e","n","g","t","h"};
    localparam logic [7:0] KEY_TE [17] = '{"t","r","a","n","s","f","e","r","-",
                                             "e","n","c","o","d","i","n","g"};
    localparam logic [7:0] KEY_CH [7] = '{"c","h","u","n","k","e","d"};

    // Result of the per-byte step, passed from the step logic to the top level.
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] byte_class;
        logic       header_start;
    } step_res_t;

    function automatic logic [7:0] low_case(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    function automatic logic is_ctl(input logic [7:0] b);
        return (b <= 8'd31) || (b == 8'd127);
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        case (b)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]",
            "?", "=", "{", "}", " ", 8'h09: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        return !b[7] && !is_ctl(b) && !is_sep(b);
    endfunction

    function automatic logic dec_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    // Hex digit value, 16 when the byte is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [7:0] t;
        t = 8'd16;
        if (dec_digit(b)) t = b - "0";
        else if (b >= "A" && b <= "F") t = b - "A" + 8'd10;
        else if (b >= "a" && b <= "f") t = b - "a" + 8'd10;
        return t[4:0];
    endfunction
endpackage

// ===== design/hrbp_step.sv =====
// Combinational next-state logic of the HTTP request byte parser.
// Depends on hrbp_pkg.
`timescale 1ns / 1ps
module hrbp_step #(
    parameter int LEN_BITS = 32
) (
    input  logic [7:0]          b,
    input  hrbp_pkg::phase_t    phase,
    input  logic                chunked,
    input  logic [LEN_BITS-1:0] rem_len,
    input  logic                any_hdr,
    input  logic [7:0]          major,
    input  logic [7:0]          minor,
    input  logic [4:0]          npos,
    input  logic [1:0]          nflags,
    input  logic [3:0]          vpos,
    input  logic [1:0]          vflags,
    input  logic [LEN_BITS-1:0] vnum,
    output hrbp_pkg::phase_t    phase_n,
    output logic                chunked_n,
    output logic [LEN_BITS-1:0] rem_len_n,
    output logic                any_hdr_n,
    output logic [7:0]          major_n,
    output logic [7:0]          minor_n,
    output logic [4:0]          npos_n,
    output logic [1:0]          nflags_n,
    output logic [3:0]          vpos_n,
    output logic [1:0]          vflags_n,
    output logic [LEN_BITS-1:0] vnum_n,
    output hrbp_pkg::step_res_t res
);
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    logic [7:0] lc;
    logic [3:0] dig;
    logic [4:0] hx;
    logic       dig_ok;
    logic [11:0] maj_x;
    logic [11:0] min_x;
    logic [LEN_BITS+3:0] vnum_x;
    logic [LEN_BITS+4:0] hex_x;
    logic       vnum_ovf;
    logic       hex_ovf;
    logic [1:0] vf_val;
    logic [3:0] vp_val;
    logic [LEN_BITS-1:0] vn_val;
    logic [LEN_BITS-1:0] rem_dec;

    always_comb
    begin
        lc = hrbp_pkg::low_case(b);
        dig = 4'(b - 8'd48);
        dig_ok = hrbp_pkg::dec_digit(b);
        hx = hrbp_pkg::hex_val(b);
        maj_x = {4'd0, major} * 12'd10 + {8'd0, dig};
        min_x = {4'd0, minor} * 12'd10 + {8'd0, dig};
        vnum_x = {4'd0, vnum} * (LEN_BITS+4)'(10) + (LEN_BITS+4)'(dig);
        vnum_ovf = |vnum_x[LEN_BITS+3:LEN_BITS];
        hex_x = {5'd0, rem_len} * (LEN_BITS+5)'(16) + (LEN_BITS+5)'(hx);
        hex_ovf = |hex_x[LEN_BITS+4:LEN_BITS];
        rem_dec = rem_len - LEN_BITS'(1);
    end

    // Name matcher against both keys; base position and flags come in.
    function automatic void name_upd(input logic [4:0] p, input logic [1:0] f,
                                     output logic [4:0] po, output logic [1:0] fo);
        logic [7:0] c;
        c = hrbp_pkg::low_case(b);
        fo = f;
        if (p >= 5'd14 || c != hrbp_pkg::KEY_CL[p[3:0]]) fo[0] = 1'b0;
        if (p >= 5'd17 || c != hrbp_pkg::KEY_TE[p[4:0] > 5'd16 ? 5'd0 : p]) fo[1] = 1'b0;
        po = (p < 5'd31) ? p + 5'd1 : p;
    endfunction

    always_comb
    begin
        logic [4:0] np_t;
        logic [1:0] nf_t;
        phase_n = phase;
        chunked_n = chunked;
        rem_len_n = rem_len;
        any_hdr_n = any_hdr;
        major_n = major;
        minor_n = minor;
        npos_n = npos;
        nflags_n = nflags;
        vpos_n = vpos;
        vflags_n = vflags;
        vnum_n = vnum;
        res = '{status: hrbp_pkg::ST_MORE, byte_class: hrbp_pkg::CLS_FRAME,
                header_start: 1'b0};
        np_t = '0;
        nf_t = '0;
        vf_val = vflags;
        vp_val = vpos;
        vn_val = vnum;

        // Value matcher for one value byte.
        if (!dig_ok) vf_val[0] = 1'b0;
        else if (vflags[0]) begin
            if (vnum_ovf) vf_val[0] = 1'b0;
            else vn_val = vnum_x[LEN_BITS-1:0];
        end
        if (vpos < 4'd7 && lc == hrbp_pkg::KEY_CH[vpos[2:0]]) vp_val = vpos + 4'd1;
        else vf_val[1] = 1'b0;

        unique case (phase)
            hrbp_pkg::P_METHOD_START:
                if (!hrbp_pkg::is_token(b)) res.status = hrbp_pkg::ST_BAD;
                else begin
                    phase_n = hrbp_pkg::P_METHOD;
                    res.byte_class = hrbp_pkg::CLS_METHOD;
                end
            hrbp_pkg::P_METHOD:
                if (b == " ") phase_n = hrbp_pkg::P_URI;
                else if (!hrbp_pkg::is_token(b)) res.status = hrbp_pkg::ST_BAD;
                else res.byte_class = hrbp_pkg::CLS_METHOD;
            hrbp_pkg::P_URI:
                if (b == " ") phase_n = hrbp_pkg::P_VH;
                else if (hrbp_pkg::is_ctl(b)) res.status = hrbp_pkg::ST_BAD;
                else res.byte_class = hrbp_pkg::CLS_URI;
            hrbp_pkg::P_VH:
                if (b != "H") res.status = hrbp_pkg::ST_BAD;
                else phase_n = hrbp_pkg::P_VT1;
            hrbp_pkg::P_VT1:
                if (b != "T") res.status = hrbp_pkg::ST_BAD;
                else phase_n = hrbp_pkg::P_VT2;
            hrbp_pkg::P_VT2:
                if (b != "T") res.status = hrbp_pkg::ST_BAD;
                else phase_n = hrbp_pkg::P_VP;
            hrbp_pkg::P_VP:
                if (b != "P") res.status = hrbp_pkg::ST_BAD;
                else phase_n = hrbp_pkg::P_VSLASH;
            hrbp_pkg::P_VSLASH:
                if (b != "/") res.status = hrbp_pkg::ST_BAD;
                else begin
                    major_n = '0;
                    minor_n = '0;
                    phase_n = hrbp_pkg::P_MAJ_START;
                end
            hrbp_pkg::P_MAJ_START, hrbp_pkg::P_MAJ:
                if (phase == hrbp_pkg::P_MAJ && b == ".") phase_n = hrbp_pkg::P_MAJ_DOT;
                else if (!dig_ok || (|maj_x[11:8])) res.status = hrbp_pkg::ST_BAD;
                else begin
                    major_n = maj_x[7:0];
                    phase_n = hrbp_pkg::P_MAJ;
                end
            hrbp_pkg::P_MAJ_DOT, hrbp_pkg::P_MIN:
                if (phase == hrbp_pkg::P_MIN && b == 8'h0d) phase_n = hrbp_pkg::P_NL1;
                else if (!dig_ok || (|min_x[11:8])) res.status = hrbp_pkg::ST_BAD;
                else begin
                    minor_n = min_x[7:0];
                    phase_n = hrbp_pkg::P_MIN;
                end
            hrbp_pkg::P_NL1, hrbp_pkg::P_NL2:
                if (b != 8'h0a) res.status = hrbp_pkg::ST_BAD;
                else phase_n = hrbp_pkg::P_LINE_START;
            hrbp_pkg::P_LINE_START:
                if (b == 8'h0d) phase_n = hrbp_pkg::P_NL3;
                else if (any_hdr && (b == " " || b == 8'h09)) phase_n = hrbp_pkg::P_LWS;
                else if (!hrbp_pkg::is_token(b)) res.status = hrbp_pkg::ST_BAD;
                else begin
                    any_hdr_n = 1'b1;
                    name_upd(5'd0, 2'b11, np_t, nf_t);
                    npos_n = np_t;
                    nflags_n = nf_t;
                    vpos_n = '0;
                    vflags_n = 2'b11;
                    vnum_n = '0;
                    phase_n = hrbp_pkg::P_NAME;
                    res.byte_class = hrbp_pkg::CLS_NAME;
                    res.header_start = 1'b1;
                end
            hrbp_pkg::P_LWS:
                if (b == 8'h0d) phase_n = hrbp_pkg::P_NL2;
                else if (b == " " || b == 8'h09) phase_n = phase;
                else if (hrbp_pkg::is_ctl(b)) res.status = hrbp_pkg::ST_BAD;
                else begin
                    vflags_n = vf_val;
                    vpos_n = vp_val;
                    vnum_n = vn_val;
                    phase_n = hrbp_pkg::P_VALUE;
                    res.byte_class = hrbp_pkg::CLS_VALUE;
                end
            hrbp_pkg::P_NAME:
                if (b == ":") begin
                    if (npos != 5'd14) nflags_n[0] = 1'b0;
                    if (npos != 5'd17) nflags_n[1] = 1'b0;
                    phase_n = hrbp_pkg::P_SP_VALUE;
                end else if (!hrbp_pkg::is_token(b)) res.status = hrbp_pkg::ST_BAD;
                else begin
                    name_upd(npos, nflags, np_t, nf_t);
                    npos_n = np_t;
                    nflags_n = nf_t;
                    res.byte_class = hrbp_pkg::CLS_NAME;
                end
            hrbp_pkg::P_SP_VALUE:
                if (b != " ") res.status = hrbp_pkg::ST_BAD;
                else phase_n = hrbp_pkg::P_VALUE;
            hrbp_pkg::P_VALUE:
                if (b == 8'h0d) begin
                    if (nflags[0]) begin
                        if (!vflags[0]) res.status = hrbp_pkg::ST_BAD;
                        else rem_len_n = vnum;
                    end else if (nflags[1] && vflags[1] && vpos == 4'd7) begin
                        chunked_n = 1'b1;
                    end
                    phase_n = hrbp_pkg::P_NL2;
                end else if (hrbp_pkg::is_ctl(b)) res.status = hrbp_pkg::ST_BAD;
                else begin
                    vflags_n = vf_val;
                    vpos_n = vp_val;
                    vnum_n = vn_val;
                    res.byte_class = hrbp_pkg::CLS_VALUE;
                end
            hrbp_pkg::P_NL3:
                if (b != 8'h0a) res.status = hrbp_pkg::ST_BAD;
                else if (chunked) phase_n = hrbp_pkg::P_CSIZE_START;
                else if (rem_len == '0) res.status = hrbp_pkg::ST_GOOD;
                else phase_n = hrbp_pkg::P_BODY;
            hrbp_pkg::P_BODY:
            begin
                rem_len_n = rem_dec;
                res.byte_class = hrbp_pkg::CLS_BODY;
                if (rem_dec == '0) res.status = hrbp_pkg::ST_GOOD;
            end
            hrbp_pkg::P_CSIZE_START:
                if (hx[4]) res.status = hrbp_pkg::ST_BAD;
                else begin
                    rem_len_n = LEN_BITS'(hx);
                    phase_n = hrbp_pkg::P_CSIZE;
                end
            hrbp_pkg::P_CSIZE:
                if (b == 8'h0d) phase_n = hrbp_pkg::P_CSIZE_END;
                else if (hx[4]) begin
                    if (b == ";" || b == " ") phase_n = hrbp_pkg::P_CPARAMS;
                    else res.status = hrbp_pkg::ST_BAD;
                end else if (hex_ovf) res.status = hrbp_pkg::ST_BAD;
                else rem_len_n = hex_x[LEN_BITS-1:0];
            hrbp_pkg::P_CPARAMS:
                if (b == 8'h0d) phase_n = hrbp_pkg::P_CSIZE_END;
            hrbp_pkg::P_CSIZE_END:
                if (b != 8'h0a) res.status = hrbp_pkg::ST_BAD;
                else if (rem_len == '0) begin
                    chunked_n = 1'b0;
                    phase_n = hrbp_pkg::P_LINE_START;
                end else phase_n = hrbp_pkg::P_CDATA;
            hrbp_pkg::P_CDATA:
            begin
                rem_len_n = rem_dec & LEN_MAX;
                if (rem_dec == '0) phase_n = hrbp_pkg::P_CDATA_CR;
                res.byte_class = hrbp_pkg::CLS_BODY;
            end
            hrbp_pkg::P_CDATA_CR:
                if (b != 8'h0d) res.status = hrbp_pkg::ST_BAD;
                else phase_n = hrbp_pkg::P_CDATA_LF;
            hrbp_pkg::P_CDATA_LF:
                if (b != 8'h0a) res.status = hrbp_pkg::ST_BAD;
                else phase_n = hrbp_pkg::P_CSIZE_START;
            default: res.status = hrbp_pkg::ST_BAD;
        endcase

        if (res.status == hrbp_pkg::ST_BAD) begin
            res.byte_class = hrbp_pkg::CLS_FRAME;
            res.header_start = 1'b0;
        end
    end
endmodule

// ===== design/http_request_byte_parser_unit.sv =====
// HTTP/1.x request byte parser: one request byte in, one tagged result out, back to
// back. The whole per-byte step (phase transition, header name/value matching,
// decimal/hex accumulators) is one pass of logic in hrbp_step between the parser
// state registers and the result register, so a new request is taken every cycle
// while the output register is empty or being drained. Restart requests
// (tuser = 1) return every flag to its reset value. Status 1 or 2 sticks until a
// restart. The result is registered and is valid in the cycle after accept.
// Depends on hrbp_pkg, hrbp_step and http_request_byte_parser_unit_defines.svh.
`timescale 1ns / 1ps
`include "http_request_byte_parser_unit_defines.svh"
module http_request_byte_parser_unit #(
    parameter int LEN_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [1:0] status, [9:2] byte_out, [12:10] byte_class,
                                   // [13] header_start, [21:14] version_major,
                                   // [29:22] version_minor, [31:30] zero
);
    hrbp_pkg::phase_t    phase_reg, phase_next;
    logic                chunked_reg, chunked_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;
    logic                any_reg, any_next;
    logic [7:0]          maj_reg, maj_next;
    logic [7:0]          min_reg, min_next;
    logic [4:0]          npos_reg, npos_next;
    logic [1:0]          nflg_reg, nflg_next;
    logic [3:0]          vpos_reg, vpos_next;
    logic [1:0]          vflg_reg, vflg_next;
    logic [LEN_BITS-1:0] vnum_reg, vnum_next;
    logic [1:0]          held_reg;
    logic                ovalid_reg;
    logic [31:0]         odata_reg;
    hrbp_pkg::step_res_t res;
    logic                acc;
    logic                restart;

    // Advance when the output slot is empty or drains this cycle.
    assign s_tready = !ovalid_reg || m_tready;
    assign acc = s_tvalid && s_tready;
    assign restart = (s_tuser == hrbp_pkg::KIND_RESTART);
    assign m_tvalid = ovalid_reg;
    assign m_tdata = odata_reg;

    hrbp_step #(.LEN_BITS(LEN_BITS)) u_step (
        .b(s_tdata), .phase(phase_reg), .chunked(chunked_reg), .rem_len(rem_reg),
        .any_hdr(any_reg), .major(maj_reg), .minor(min_reg), .npos(npos_reg),
        .nflags(nflg_reg), .vpos(vpos_reg), .vflags(vflg_reg), .vnum(vnum_reg),
        .phase_n(phase_next), .chunked_n(chunked_next), .rem_len_n(rem_next),
        .any_hdr_n(any_next), .major_n(maj_next), .minor_n(min_next),
        .npos_n(npos_next), .nflags_n(nflg_next), .vpos_n(vpos_next),
        .vflags_n(vflg_next), .vnum_n(vnum_next), .res(res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= hrbp_pkg::P_METHOD_START;
            chunked_reg <= 1'b0;
            rem_reg <= '0;
            any_reg <= 1'b0;
            maj_reg <= '0;
            min_reg <= '0;
            npos_reg <= '0;
            nflg_reg <= 2'b11;
            vpos_reg <= '0;
            vflg_reg <= 2'b11;
            vnum_reg <= '0;
            held_reg <= hrbp_pkg::ST_MORE;
            ovalid_reg <= 1'b0;
            odata_reg <= '0;
        end else begin
            if (acc) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
            if (acc) begin
                if (restart) begin
                    // Drop all parse state back to method start.
                    phase_reg <= hrbp_pkg::P_METHOD_START;
                    chunked_reg <= 1'b0;
                    rem_reg <= '0;
                    any_reg <= 1'b0;
                    maj_reg <= '0;
                    min_reg <= '0;
                    npos_reg <= '0;
                    nflg_reg <= 2'b11;
                    vpos_reg <= '0;
                    vflg_reg <= 2'b11;
                    vnum_reg <= '0;
                    held_reg <= hrbp_pkg::ST_MORE;
                    odata_reg <= {30'd0, hrbp_pkg::ST_MORE};
                end else if (held_reg != hrbp_pkg::ST_MORE) begin
                    // Hold the final status; state is frozen.
                    odata_reg <= {2'b00, min_reg, maj_reg, 1'b0, hrbp_pkg::CLS_FRAME,
                                  s_tdata, held_reg};
                end else begin
                    phase_reg <= phase_next;
                    chunked_reg <= chunked_next;
                    rem_reg <= rem_next;
                    any_reg <= any_next;
                    maj_reg <= maj_next;
                    min_reg <= min_next;
                    npos_reg <= npos_next;
                    nflg_reg <= nflg_next;
                    vpos_reg <= vpos_next;
                    vflg_reg <= vflg_next;
                    vnum_reg <= vnum_next;
                    held_reg <= res.status;
                    odata_reg <= {2'b00, min_next, maj_next, res.header_start,
                                  res.byte_class, s_tdata, res.status};
                end
            end
        end
    end

    `HRBP_ASSERT_NEXT(a_restart_clears, clk, rst_n, acc && restart, held_reg == hrbp_pkg::ST_MORE && phase_reg == hrbp_pkg::P_METHOD_START, "restart did not clear parser")
    `HRBP_ASSERT_NEXT(a_held_sticks, clk, rst_n, acc && !restart && held_reg != hrbp_pkg::ST_MORE, held_reg == $past(held_reg), "held status changed without restart")
    `HRBP_ASSERT_IMPL(a_bad_no_class, clk, rst_n, m_tvalid && m_tdata[1:0] == hrbp_pkg::ST_BAD, m_tdata[13:10] == 4'd0, "malformed result carries a class")
endmodule
